>>> design/vfbd_pkg.sv
// Package for the vector field bilinear drag block.
// Holds the request/response structs, the fixed-point constants and the register codes.
// No dependencies.
package vfbd_pkg;

    localparam int MAX_SIDE  = 64;
    localparam int FRAC_BITS = 8;
    localparam int COORD_W   = 6;
    localparam int BANK_AW   = 2 * (COORD_W - 1);
    localparam int BANK_CNT  = 4;

    localparam logic [1:0] CFG_GRID_HEIGHT = 2'd0;
    localparam logic [1:0] CFG_GRID_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_DRAG_COEFF  = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [5:0]         node_x;
        logic [5:0]         node_y;
        logic signed [15:0] node_vx;
        logic signed [15:0] node_vy;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] particle_vx;
        logic signed [15:0] particle_vy;
    } t_req;

    typedef struct packed {
        logic signed [15:0] water_vx;
        logic signed [15:0] water_vy;
        logic signed [15:0] force_x;
        logic signed [15:0] force_y;
        logic               outside;
        logic               saturated;
    } t_rsp;

endpackage

>>> design/vector_field_bilinear_drag_top.sv
// Throughput: one request per cycle while the result register is not held;
// the velocity store is split into four banks by node parity so the four
// cell corners come from one read port each.
// Reset (synchronous, active low) clears the pipeline valids and loads the
// register defaults; the store holds no reset value and needs no clearing.
// Depends on vfbd_pkg.
module vector_field_bilinear_drag_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  vfbd_pkg::t_req    i_req,
    output logic              o_valid,
    input  logic              i_stall,
    output vfbd_pkg::t_rsp    o_rsp,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data
);

    localparam int FB = vfbd_pkg::FRAC_BITS;
    localparam int IW = 16 - FB;     // integer part width
    localparam int FW = FB + 1;      // fraction, signed
    localparam int GW = FB + 2;      // one minus fraction, signed
    localparam int AW = vfbd_pkg::BANK_AW;
    localparam int CW = vfbd_pkg::COORD_W;

    // Configuration registers
    logic [5:0]  r_grid_h, r_grid_w;
    logic [15:0] r_drag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_h <= 6'd63;
            r_grid_w <= 6'd63;
            r_drag   <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vfbd_pkg::CFG_GRID_HEIGHT: r_grid_h <= i_cfg_data[5:0];
                vfbd_pkg::CFG_GRID_WIDTH:  r_grid_w <= i_cfg_data[5:0];
                vfbd_pkg::CFG_DRAG_COEFF:  r_drag   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the whole pipeline unless the result register is held
    logic w_adv, w_acc;
    logic r_ov;
    assign w_adv   = !r_ov || !i_stall;
    assign o_stall = !w_adv;
    assign w_acc   = i_valid && w_adv;

    // Split position into truncated integer part and signed fraction
    logic [FB-1:0]        w_lx, w_ly;
    logic signed [IW-1:0] w_ix, w_iy;
    logic signed [FW-1:0] w_fx, w_fy;
    logic                 w_negx, w_negy, w_out;
    logic [CW-1:0]        w_x0, w_y0, w_x1, w_y1;

    assign w_lx   = i_req.pos_x[FB-1:0];
    assign w_ly   = i_req.pos_y[FB-1:0];
    assign w_negx = i_req.pos_x[15] && (w_lx != '0);
    assign w_negy = i_req.pos_y[15] && (w_ly != '0);
    assign w_ix   = i_req.pos_x[15:FB] + IW'(w_negx);
    assign w_iy   = i_req.pos_y[15:FB] + IW'(w_negy);
    assign w_fx   = w_negx ? $signed({1'b1, w_lx}) : $signed({1'b0, w_lx});
    assign w_fy   = w_negy ? $signed({1'b1, w_ly}) : $signed({1'b0, w_ly});
    assign w_out  = w_ix[IW-1] || w_iy[IW-1]
                  || (w_ix[IW-2:0] > (IW-1)'(r_grid_w))
                  || (w_iy[IW-2:0] > (IW-1)'(r_grid_h));
    assign w_x0   = w_ix[CW-1:0];
    assign w_y0   = w_iy[CW-1:0];
    assign w_x1   = w_x0 + CW'(1);
    assign w_y1   = w_y0 + CW'(1);

    // Banked velocity store, bank index {x parity, y parity}
    logic [31:0] r_rd [vfbd_pkg::BANK_CNT];

    for (genvar b = 0; b < vfbd_pkg::BANK_CNT; b++) begin : g_bank
        localparam logic [1:0] BI = 2'(b);
        logic [31:0]   r_mem [2**AW];
        logic [CW-1:0] w_xs, w_ys;
        logic          w_we;

        assign w_xs = (w_x0[0] == BI[1]) ? w_x0 : w_x1;
        assign w_ys = (w_y0[0] == BI[0]) ? w_y0 : w_y1;
        assign w_we = w_acc && (i_req.cmd == vfbd_pkg::CMD_WRITE)
                    && (i_req.node_x[0] == BI[1]) && (i_req.node_y[0] == BI[0]);

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_mem[{i_req.node_x[CW-1:1], i_req.node_y[CW-1:1]}] <=
                    {i_req.node_vy, i_req.node_vx};
            end
            if (w_adv) begin
                r_rd[b] <= r_mem[{w_xs[CW-1:1], w_ys[CW-1:1]}];
            end
        end
    end

    // Stage 1 registers: request meta data next to the read data
    logic                 r_v1, r_q1, r_o1, r_top1, r_rgt1, r_px1, r_py1;
    logic signed [FW-1:0] r_fx1, r_fy1;
    logic signed [15:0]   r_pvx1, r_pvy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (w_adv) r_v1 <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q1   <= (i_req.cmd == vfbd_pkg::CMD_QUERY);
            r_o1   <= w_out;
            r_top1 <= (w_y0 == r_grid_h);
            r_rgt1 <= (w_x0 == r_grid_w);
            r_px1  <= w_x0[0];
            r_py1  <= w_y0[0];
            r_fx1  <= w_fx;
            r_fy1  <= w_fy;
            r_pvx1 <= i_req.particle_vx;
            r_pvy1 <= i_req.particle_vy;
        end
    end

    // Pick corners out of the banks, zero those beyond the top/right border
    logic signed [15:0] w_cx [4], w_cy [4];
    logic signed [GW-1:0] w_gx1, w_gy1;
    logic signed [25:0] w_p [8];
    logic signed [26:0] w_r1x, w_r1y, w_r2x, w_r2y;
    logic [1:0] w_bi [4];
    logic       w_keep [4];

    assign w_bi[0] = {r_px1, r_py1};
    assign w_bi[1] = {r_px1, ~r_py1};
    assign w_bi[2] = {~r_px1, r_py1};
    assign w_bi[3] = {~r_px1, ~r_py1};
    assign w_keep[0] = 1'b1;
    assign w_keep[1] = !r_top1;
    assign w_keep[2] = !r_rgt1;
    assign w_keep[3] = !r_top1 && !r_rgt1;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_cx[c] = w_keep[c] ? $signed(r_rd[w_bi[c]][15:0])  : 16'sd0;
            w_cy[c] = w_keep[c] ? $signed(r_rd[w_bi[c]][31:16]) : 16'sd0;
        end
    end

    assign w_gx1 = $signed(GW'(1 << FB)) - GW'(r_fx1);
    assign w_gy1 = $signed(GW'(1 << FB)) - GW'(r_fy1);
    assign w_p[0] = w_gx1 * w_cx[0];
    assign w_p[1] = r_fx1 * w_cx[2];
    assign w_p[2] = w_gx1 * w_cy[0];
    assign w_p[3] = r_fx1 * w_cy[2];
    assign w_p[4] = w_gx1 * w_cx[1];
    assign w_p[5] = r_fx1 * w_cx[3];
    assign w_p[6] = w_gx1 * w_cy[1];
    assign w_p[7] = r_fx1 * w_cy[3];
    assign w_r1x = 27'(w_p[0]) + 27'(w_p[1]);
    assign w_r1y = 27'(w_p[2]) + 27'(w_p[3]);
    assign w_r2x = 27'(w_p[4]) + 27'(w_p[5]);
    assign w_r2y = 27'(w_p[6]) + 27'(w_p[7]);

    // Stage 2: row blends along x
    logic                 r_v2, r_q2, r_o2;
    logic signed [FW-1:0] r_fy2;
    logic signed [GW-1:0] r_gy2;
    logic signed [26:0]   r_r1x2, r_r1y2, r_r2x2, r_r2y2;
    logic signed [15:0]   r_pvx2, r_pvy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (w_adv) r_v2 <= r_v1;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q2   <= r_q1;
            r_o2   <= r_o1;
            r_fy2  <= r_fy1;
            r_gy2  <= w_gy1;
            r_r1x2 <= w_r1x;
            r_r1y2 <= w_r1y;
            r_r2x2 <= w_r2x;
            r_r2y2 <= w_r2y;
            r_pvx2 <= r_pvx1;
            r_pvy2 <= r_pvy1;
        end
    end

    // Blend along y
    logic signed [36:0] w_q [4];
    logic signed [37:0] w_sx, w_sy;

    assign w_q[0] = r_gy2 * r_r1x2;
    assign w_q[1] = r_fy2 * r_r2x2;
    assign w_q[2] = r_gy2 * r_r1y2;
    assign w_q[3] = r_fy2 * r_r2y2;
    assign w_sx   = 38'(w_q[0]) + 38'(w_q[1]);
    assign w_sy   = 38'(w_q[2]) + 38'(w_q[3]);

    // Stage 3: full-precision blended sums
    logic               r_v3, r_q3, r_o3;
    logic signed [37:0] r_sx3, r_sy3;
    logic signed [15:0] r_pvx3, r_pvy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (w_adv) r_v3 <= r_v2;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q3   <= r_q2;
            r_o3   <= r_o2;
            r_sx3  <= w_sx;
            r_sy3  <= w_sy;
            r_pvx3 <= r_pvx2;
            r_pvy3 <= r_pvy2;
        end
    end

    // Round half up, saturate water velocity, form water minus particle
    logic signed [37:0] w_rx, w_ry;
    logic signed [37-2*FB:0] w_tx, w_ty;
    logic signed [15:0] w_wx, w_wy;
    logic               w_satx, w_saty;

    assign w_rx = r_sx3 + 38'(1 << (2*FB-1));
    assign w_ry = r_sy3 + 38'(1 << (2*FB-1));
    assign w_tx = w_rx[37:2*FB];
    assign w_ty = w_ry[37:2*FB];
    assign w_satx = (w_tx > 32767) || (w_tx < -32768);
    assign w_saty = (w_ty > 32767) || (w_ty < -32768);

    always_comb begin
        if (r_o3) begin
            w_wx = 16'sd0;
        end else if (w_satx) begin
            w_wx = w_tx[37-2*FB] ? -16'sd32768 : 16'sd32767;
        end else begin
            w_wx = w_tx[15:0];
        end
        if (r_o3) begin
            w_wy = 16'sd0;
        end else if (w_saty) begin
            w_wy = w_ty[37-2*FB] ? -16'sd32768 : 16'sd32767;
        end else begin
            w_wy = w_ty[15:0];
        end
    end

    // Stage 4: water velocity and velocity difference
    logic               r_v4, r_q4, r_o4, r_s4;
    logic signed [15:0] r_wx4, r_wy4;
    logic signed [16:0] r_dx4, r_dy4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else if (w_adv) r_v4 <= r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q4  <= r_q3;
            r_o4  <= r_o3;
            r_s4  <= !r_o3 && (w_satx || w_saty);
            r_wx4 <= w_wx;
            r_wy4 <= w_wy;
            r_dx4 <= 17'(w_wx) - 17'(r_pvx3);
            r_dy4 <= 17'(w_wy) - 17'(r_pvy3);
        end
    end

    // Stage 5: drag products k * (water - particle)
    logic               r_v5, r_q5, r_o5, r_s5;
    logic signed [15:0] r_wx5, r_wy5;
    logic signed [33:0] r_fx5, r_fy5;
    logic signed [16:0] w_k;

    assign w_k = $signed({1'b0, r_drag});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v5 <= 1'b0;
        else if (w_adv) r_v5 <= r_v4;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q5  <= r_q4;
            r_o5  <= r_o4;
            r_s5  <= r_s4;
            r_wx5 <= r_wx4;
            r_wy5 <= r_wy4;
            r_fx5 <= w_k * r_dx4;
            r_fy5 <= w_k * r_dy4;
        end
    end

    // Round and saturate the force
    logic signed [33:0]    w_gx, w_gy;
    logic signed [33-FB:0] w_hx, w_hy;
    logic signed [15:0]    w_ffx, w_ffy;
    logic                  w_sfx, w_sfy;

    assign w_gx  = r_fx5 + 34'(1 << (FB-1));
    assign w_gy  = r_fy5 + 34'(1 << (FB-1));
    assign w_hx  = w_gx[33:FB];
    assign w_hy  = w_gy[33:FB];
    assign w_sfx = (w_hx > 32767) || (w_hx < -32768);
    assign w_sfy = (w_hy > 32767) || (w_hy < -32768);
    assign w_ffx = w_sfx ? (w_hx[33-FB] ? -16'sd32768 : 16'sd32767) : w_hx[15:0];
    assign w_ffy = w_sfy ? (w_hy[33-FB] ? -16'sd32768 : 16'sd32767) : w_hy[15:0];

    // Output register; write requests give an all-zero result
    vfbd_pkg::t_rsp r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_adv) r_ov <= r_v5;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_q5) begin
                r_rsp.water_vx  <= r_wx5;
                r_rsp.water_vy  <= r_wy5;
                r_rsp.force_x   <= w_ffx;
                r_rsp.force_y   <= w_ffy;
                r_rsp.outside   <= r_o5;
                r_rsp.saturated <= r_s5 || w_sfx || w_sfy;
            end else begin
                r_rsp <= '0;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_rsp   = r_rsp;

    // An outside query never carries water velocity
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.outside) |-> (o_rsp.water_vx == 0 && o_rsp.water_vy == 0))
        else $error("outside result has nonzero water velocity");

    // A finished item moves into the output register when the pipe advances
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && w_adv) |=> o_valid)
        else $error("pipeline item lost at output");

    // Read data holds while the pipe is stalled
    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ((r_rd[0] === $past(r_rd[0])) && (r_rd[3] === $past(r_rd[3]))))
        else $error("bank read data changed during stall");

endmodule

>>> tb/vector_field_bilinear_drag_top_tb.sv
// Testbench for vector_field_bilinear_drag_top: bilinear water velocity lookup and drag.
// Streams node writes and point queries, predicts each response and compares in order.
// Depends on vfbd_pkg and the vector_field_bilinear_drag_top RTL.
`timescale 1ns / 100ps

module vector_field_bilinear_drag_top_tb;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam int  LATENCY    = 6;
    localparam int  CYCLE_CAP  = 1000000;
    localparam int  HOLD_AT    = 700;
    localparam int  HOLD_LEN   = 300;
    localparam int  MAX_REPORT = 10;
    localparam int  FILL_SIDE  = 16;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_stall;
    vfbd_pkg::t_req i_req = '0;
    logic           o_valid;
    logic           i_stall = 1'b0;
    vfbd_pkg::t_rsp o_rsp;
    logic           i_cfg_we = 1'b0;
    logic [1:0]     i_cfg_idx = '0;
    logic [15:0]    i_cfg_data = '0;

    vector_field_bilinear_drag_top i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_req     (i_req),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_rsp     (o_rsp),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the grid and registers
    logic [31:0] node_mem [0:vfbd_pkg::MAX_SIDE*vfbd_pkg::MAX_SIDE-1];
    logic [5:0]  sh_height = 6'd63;
    logic [5:0]  sh_width  = 6'd63;
    logic [15:0] sh_drag   = 16'd256;

    vfbd_pkg::t_req pending_reqs[$];
    vfbd_pkg::t_rsp expected_rsps[$];
    int   n_accepted = 0;
    int   n_errors = 0;
    int   cycle_cnt = 0;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   hold_left = 0;
    bit   hold_used = 0;
    bit   quiet = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint node_comp(longint x, longint y, bit upper);
        logic [31:0] e;
        if (x >= vfbd_pkg::MAX_SIDE || y >= vfbd_pkg::MAX_SIDE) return 0;
        e = node_mem[x * vfbd_pkg::MAX_SIDE + y];
        return upper ? longint'($signed(e[31:16])) : longint'($signed(e[15:0]));
    endfunction

    function automatic longint clip16(longint v, inout bit sat);
        if (v > 32767) begin
            sat = 1;
            return 32767;
        end
        if (v < -32768) begin
            sat = 1;
            return -32768;
        end
        return v;
    endfunction

    // Interpolate the cell corners and form the drag against the particle velocity
    function automatic vfbd_pkg::t_rsp drag_predict(vfbd_pkg::t_req r);
        vfbd_pkg::t_rsp o;
        longint one, px, py, ix, iy, fx, fy, gx, gy, m, n, wx, wy, fcx, fcy;
        longint v[4][2];
        longint r1, r2;
        bit     sat;
        o = '0;
        if (r.cmd == vfbd_pkg::CMD_WRITE) return o;
        one = 1 << vfbd_pkg::FRAC_BITS;
        sat = 0;
        wx = 0;
        wy = 0;
        px = longint'(r.pos_x);
        py = longint'(r.pos_y);
        ix = px / one;
        iy = py / one;
        fx = px - ix * one;
        fy = py - iy * one;
        m = sh_width;
        n = sh_height;
        if (ix < 0 || iy < 0 || ix > m || iy > n) begin
            o.outside = 1'b1;
        end else begin
            gx = one - fx;
            gy = one - fy;
            for (int c = 0; c < 2; c++) begin
                v[0][c] = node_comp(ix, iy, bit'(c));
                v[1][c] = (iy < n) ? node_comp(ix, iy + 1, bit'(c)) : 0;
                v[2][c] = (ix < m) ? node_comp(ix + 1, iy, bit'(c)) : 0;
                v[3][c] = (ix < m && iy < n) ? node_comp(ix + 1, iy + 1, bit'(c)) : 0;
            end
            r1 = gx * v[0][0] + fx * v[2][0];
            r2 = gx * v[1][0] + fx * v[3][0];
            wx = clip16((gy * r1 + fy * r2 + (1 << (2*vfbd_pkg::FRAC_BITS-1)))
                        >>> (2*vfbd_pkg::FRAC_BITS), sat);
            r1 = gx * v[0][1] + fx * v[2][1];
            r2 = gx * v[1][1] + fx * v[3][1];
            wy = clip16((gy * r1 + fy * r2 + (1 << (2*vfbd_pkg::FRAC_BITS-1)))
                        >>> (2*vfbd_pkg::FRAC_BITS), sat);
        end
        fcx = -longint'(sh_drag) * (longint'(r.particle_vx) - wx);
        fcy = -longint'(sh_drag) * (longint'(r.particle_vy) - wy);
        fcx = clip16((fcx + (1 << (vfbd_pkg::FRAC_BITS-1))) >>> vfbd_pkg::FRAC_BITS, sat);
        fcy = clip16((fcy + (1 << (vfbd_pkg::FRAC_BITS-1))) >>> vfbd_pkg::FRAC_BITS, sat);
        o.water_vx  = wx[15:0];
        o.water_vy  = wy[15:0];
        o.force_x   = fcx[15:0];
        o.force_y   = fcy[15:0];
        o.saturated = sat;
        return o;
    endfunction

    // Driver: predict on accept, then offer the next request after a gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_rsps.push_back(drag_predict(i_req));
                if (i_req.cmd == vfbd_pkg::CMD_WRITE)
                    node_mem[i_req.node_x * vfbd_pkg::MAX_SIDE + i_req.node_y] =
                        {i_req.node_vy, i_req.node_vx};
                n_accepted <= n_accepted + 1;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    i_req <= pending_reqs.pop_front();
                    i_valid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started once mid-run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_used && n_accepted >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_used <= 1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: compare accepted responses with the oldest prediction
    always @(posedge i_clk) begin
        vfbd_pkg::t_rsp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rsps.size() == 0) begin
                n_errors <= n_errors + 1;
                if (n_errors < MAX_REPORT)
                    $display("unexpected response %h", o_rsp);
            end else begin
                want = expected_rsps.pop_front();
                if (want.water_vx !== o_rsp.water_vx || want.water_vy !== o_rsp.water_vy ||
                    want.force_x !== o_rsp.force_x || want.force_y !== o_rsp.force_y ||
                    want.outside !== o_rsp.outside || want.saturated !== o_rsp.saturated) begin
                    n_errors <= n_errors + 1;
                    if (n_errors < MAX_REPORT)
                        $display("response error: expected %h actual %h", want, o_rsp);
                end
            end
        end
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            recv_gap <= pick_gap();
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("vector_field_bilinear_drag_top: mismatch");
            $finish;
        end
    end

    function automatic vfbd_pkg::t_req node_write(logic [5:0] x, logic [5:0] y,
                                                  logic [15:0] vx, logic [15:0] vy);
        vfbd_pkg::t_req r;
        r = '0;
        r.cmd = vfbd_pkg::CMD_WRITE;
        r.node_x = x;
        r.node_y = y;
        r.node_vx = vx;
        r.node_vy = vy;
        r.pos_x = 16'($urandom);
        r.pos_y = 16'($urandom);
        r.particle_vx = 16'($urandom);
        r.particle_vy = 16'($urandom);
        return r;
    endfunction

    function automatic vfbd_pkg::t_req query(logic [15:0] px, logic [15:0] py,
                                             logic [15:0] pvx, logic [15:0] pvy);
        vfbd_pkg::t_req r;
        r = '0;
        r.cmd = vfbd_pkg::CMD_QUERY;
        r.node_x = 6'($urandom);
        r.node_y = 6'($urandom);
        r.node_vx = 16'($urandom);
        r.node_vy = 16'($urandom);
        r.pos_x = px;
        r.pos_y = py;
        r.particle_vx = pvx;
        r.particle_vy = pvy;
        return r;
    endfunction

    // Random query position, mostly in or near the grid
    function automatic logic [15:0] rand_pos(int top);
        if ($urandom_range(0, 19) == 0) return 16'($urandom);
        return 16'($urandom_range(0, (top + 3) * 256) - 512);
    endfunction

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || i_valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [5:0] h, logic [5:0] w, logic [15:0] k);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= vfbd_pkg::CFG_GRID_HEIGHT;
        i_cfg_data <= {10'($urandom_range(0, 1023)), h};
        @(posedge i_clk);
        i_cfg_idx <= vfbd_pkg::CFG_GRID_WIDTH;
        i_cfg_data <= {10'($urandom_range(0, 1023)), w};
        @(posedge i_clk);
        i_cfg_idx <= vfbd_pkg::CFG_DRAG_COEFF;
        i_cfg_data <= k;
        @(posedge i_clk);
        i_cfg_idx <= CFG_SPARE;
        i_cfg_data <= 16'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sh_height = h;
        sh_width = w;
        sh_drag = k;
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0)
                pending_reqs.push_back(node_write(6'($urandom), 6'($urandom),
                                                  16'($urandom), 16'($urandom)));
            else
                pending_reqs.push_back(query(rand_pos(int'(sh_width)),
                                             rand_pos(int'(sh_height)),
                                             16'($urandom), 16'($urandom)));
        end
        wait_idle();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the low corner of the grid; every later grid size stays inside it
        quiet = 1;
        for (int x = 0; x < FILL_SIDE; x++)
            for (int y = 0; y < FILL_SIDE; y++)
                pending_reqs.push_back(node_write(6'(x), 6'(y), 16'($urandom),
                                                  16'($urandom)));
        wait_idle();
        quiet = 0;

        // Directed: extreme nodes, borders, negative fractions, outside cells
        pending_reqs.push_back(node_write(0, 0, 16'h7fff, 16'h8000));
        pending_reqs.push_back(node_write(1, 0, 16'h7fff, 16'h8000));
        pending_reqs.push_back(node_write(0, 1, 16'h7fff, 16'h8000));
        pending_reqs.push_back(node_write(63, 63, 16'h8000, 16'h7fff));
        pending_reqs.push_back(node_write(63, 8, 16'($urandom), 16'($urandom)));
        pending_reqs.push_back(node_write(63, 9, 16'($urandom), 16'($urandom)));
        pending_reqs.push_back(node_write(8, 63, 16'($urandom), 16'($urandom)));
        pending_reqs.push_back(node_write(9, 63, 16'($urandom), 16'($urandom)));
        pending_reqs.push_back(query(16'h0080, 16'h0080, 16'h0000, 16'h0000));
        pending_reqs.push_back(query(16'hffff, 16'hff80, 16'h7fff, 16'h8000));
        pending_reqs.push_back(query(16'hff00, 16'h0000, 16'h0000, 16'h0000));
        pending_reqs.push_back(query(16'h0000, 16'hff00, 16'h8000, 16'h7fff));
        pending_reqs.push_back(query(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
        pending_reqs.push_back(query(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        pending_reqs.push_back(query(16'h3f80, 16'h3f80, 16'h0100, 16'hff00));
        pending_reqs.push_back(query(16'h3f40, 16'h0820, 16'h0000, 16'h0000));
        pending_reqs.push_back(query(16'h0820, 16'h3f40, 16'h0000, 16'h0000));
        pending_reqs.push_back(query(16'h4000, 16'h0000, 16'h0000, 16'h0000));
        pending_reqs.push_back(query(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        wait_idle();

        set_regs(6'd0, 6'd0, 16'hffff);
        pending_reqs.push_back(query(16'h0080, 16'h0040, 16'h7fff, 16'h8000));
        pending_reqs.push_back(query(16'h0100, 16'h0000, 16'h0000, 16'h0000));
        pending_reqs.push_back(query(16'h00ff, 16'h00ff, 16'h8000, 16'h7fff));
        random_phase(150);

        set_regs(6'd15, 6'd0, 16'h0000);
        pending_reqs.push_back(query(16'h0080, 16'h0f80, 16'h7fff, 16'h7fff));
        random_phase(150);

        // Long streaming phases; the hold-off fires during one of them
        set_regs(6'd15, 6'd15, 16'h0100);
        random_phase(350);
        set_regs(6'($urandom_range(0, 15)), 6'($urandom_range(0, 15)), 16'($urandom));
        random_phase(200);
        set_regs(6'($urandom_range(1, 8)), 6'($urandom_range(1, 8)),
                 16'($urandom_range(0, 2048)));
        random_phase(400);

        repeat (LATENCY * 4) @(posedge i_clk);
        if (n_errors == 0 && expected_rsps.size() == 0)
            $display("vector_field_bilinear_drag_top: match");
        else
            $display("vector_field_bilinear_drag_top: mismatch");
        $finish;
    end

endmodule
